>>> rtl/serial_command_parser_defines.svh
// Assertion macros shared by the serial command parser RTL.
`ifndef SERIAL_COMMAND_PARSER_DEFINES_SVH
`define SERIAL_COMMAND_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define SCP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define SCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SCP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define SCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/scp_pkg.sv
// Types and constants of the serial command parser.
package scp_pkg;

    localparam int unsigned ByteW = 8;

    // Parser states
    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_F    = 3'd1,
        ST_R    = 3'd2,
        ST_M    = 3'd3,
        ST_FM   = 3'd4,
        ST_V    = 3'd5,
        ST_A    = 3'd6,
        ST_CALC = 3'd7
    } parse_state_t;

    // Characters and formula codes
    localparam logic [ByteW-1:0] CH_A      = 8'h41;
    localparam logic [ByteW-1:0] CH_C      = 8'h43;
    localparam logic [ByteW-1:0] CH_F      = 8'h46;
    localparam logic [ByteW-1:0] CH_K      = 8'h4B;
    localparam logic [ByteW-1:0] CH_M      = 8'h4D;
    localparam logic [ByteW-1:0] CH_R      = 8'h52;
    localparam logic [ByteW-1:0] CH_V      = 8'h56;
    localparam logic [ByteW-1:0] CH_ONE    = 8'h31;
    localparam logic [ByteW-1:0] CH_TWO    = 8'h32;
    localparam logic [ByteW-1:0] CASE_GAP  = 8'h20;
    localparam logic [ByteW-1:0] FORM_ADD  = 8'd35;
    localparam logic [ByteW-1:0] FORM_DBL  = 8'd40;
    localparam logic [ByteW-1:0] ADD_CONST = 8'd10;

    // Position of a byte inside an acknowledge run
    typedef enum logic [2:0] {
        POS_A     = 3'd0,
        POS_C     = 3'd1,
        POS_K     = 3'd2,
        POS_DIGIT = 3'd3,
        POS_CALC  = 3'd4
    } run_pos_t;

    // One transmit run handed from parser to emitter
    typedef struct packed {
        logic             emit;
        logic [ByteW-1:0] digit;
        logic             has_calc;
        logic [ByteW-1:0] calc;
    } run_desc_t;

    // Emitter status seen by the parser
    typedef struct packed {
        logic busy;
        logic ending;
    } emit_status_t;

    // Either-case letter match
    function automatic logic is_letter(input logic [ByteW-1:0] b,
                                       input logic [ByteW-1:0] upper);
        return (b == upper) || (b == (upper + CASE_GAP));
    endfunction

endpackage

>>> rtl/scp_parser.sv
// Keyword parser: state, stored formula and run descriptor per received byte.
module scp_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [scp_pkg::ByteW-1:0]     in_byte,
    input  scp_pkg::emit_status_t         emit_sts,
    output logic                          fire,
    output scp_pkg::run_desc_t            desc
);
    import scp_pkg::*;

    parse_state_t     state_reg, state_next;
    logic [ByteW-1:0] formula_reg, formula_next;
    logic             nonzero;
    logic             run_ok;

    assign nonzero = (in_byte != '0);
    assign run_ok  = !emit_sts.busy || emit_sts.ending;
    assign fire    = in_valid && (!desc.emit || run_ok);

    // Advance state and stored formula on each consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            formula_reg <= '0;
        end
        else if (fire)
        begin
            state_reg   <= state_next;
            formula_reg <= formula_next;
        end
    end

    // Next state and run descriptor
    always_comb
    begin
        state_next    = state_reg;
        formula_next  = formula_reg;
        desc.emit     = 1'b0;
        desc.digit    = CH_ONE;
        desc.has_calc = 1'b0;
        desc.calc     = '0;
        if (nonzero)
        begin
            unique case (state_reg)
                ST_IDLE: state_next = is_letter(in_byte, CH_F) ? ST_F : ST_IDLE;
                ST_F:    state_next = is_letter(in_byte, CH_R) ? ST_R : ST_IDLE;
                ST_R:    state_next = is_letter(in_byte, CH_M) ? ST_M : ST_IDLE;
                ST_M:
                begin
                    formula_next = in_byte;
                    desc.emit    = 1'b1;
                    state_next   = ST_FM;
                end
                ST_FM:
                begin
                    if (is_letter(in_byte, CH_V))      state_next = ST_V;
                    else if (is_letter(in_byte, CH_C)) state_next = ST_IDLE;
                    else                               state_next = ST_FM;
                end
                ST_V:
                begin
                    if (is_letter(in_byte, CH_A))      state_next = ST_A;
                    else if (is_letter(in_byte, CH_C)) state_next = ST_IDLE;
                    else                               state_next = ST_FM;
                end
                ST_A:
                begin
                    if (is_letter(in_byte, CH_R))      state_next = ST_CALC;
                    else if (is_letter(in_byte, CH_C)) state_next = ST_IDLE;
                    else                               state_next = ST_FM;
                end
                ST_CALC:
                begin
                    desc.emit  = 1'b1;
                    desc.digit = CH_TWO;
                    if (formula_reg == FORM_ADD)
                    begin
                        desc.has_calc = 1'b1;
                        desc.calc     = in_byte + ADD_CONST;
                    end
                    else if (formula_reg == FORM_DBL)
                    begin
                        desc.has_calc = 1'b1;
                        desc.calc     = {in_byte[ByteW-2:0], 1'b0};
                    end
                    state_next = ST_IDLE;
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/scp_emitter.sv
// Run register that plays an acknowledge run out one beat per cycle while m_tready is high.
module scp_emitter (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  scp_pkg::run_desc_t        desc,
    output scp_pkg::emit_status_t     sts,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [scp_pkg::ByteW-1:0] m_tdata,
    output logic                      m_tuser,
    output logic                      m_tlast
);
    import scp_pkg::*;

    logic             valid_reg;
    run_pos_t         pos_reg;
    logic [ByteW-1:0] digit_reg;
    logic             has_calc_reg;
    logic [ByteW-1:0] calc_reg;
    logic             beat;

    assign beat       = valid_reg && m_tready;
    assign m_tvalid   = valid_reg;
    assign m_tuser    = (pos_reg == POS_A);
    assign m_tlast    = has_calc_reg ? (pos_reg == POS_CALC) : (pos_reg == POS_DIGIT);
    assign sts.busy   = valid_reg;
    assign sts.ending = beat && m_tlast;

    // Select the byte at the current run position
    always_comb
    begin
        unique case (pos_reg)
            POS_A:     m_tdata = CH_A;
            POS_C:     m_tdata = CH_C;
            POS_K:     m_tdata = CH_K;
            POS_DIGIT: m_tdata = digit_reg;
            POS_CALC:  m_tdata = calc_reg;
            default:   m_tdata = calc_reg;
        endcase
    end

    // Load a new run or advance through the current one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= POS_A;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            pos_reg   <= POS_A;
        end
        else if (beat)
        begin
            if (m_tlast)
                valid_reg <= 1'b0;
            pos_reg <= run_pos_t'(pos_reg + 3'd1);
        end
    end

    // Hold run payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            digit_reg    <= desc.digit;
            has_calc_reg <= desc.has_calc;
            calc_reg     <= desc.calc;
        end
    end

endmodule

>>> rtl/serial_command_parser.sv
// Serial command parser: FRM/VAR keyword parsing with acknowledge and result output.
// Flow: a byte is registered, parsed from the input register, and loads the run register,
// which then drives its first beat; a run of four or five beats leaves at one beat per
// cycle while m_tready is high. One byte is taken per cycle while it makes no beats; a
// byte that makes a run waits until the run register is free or ending its last beat.
// Reset: rst_n clears parser state to idle, stored formula to zero, all valids low.
`include "serial_command_parser_defines.svh"
module serial_command_parser (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [scp_pkg::ByteW-1:0] s_tdata,   // [7:0] rx_byte
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [scp_pkg::ByteW-1:0] m_tdata,   // [7:0] tx_byte
    output logic                      m_tuser,   // [0] led_toggle
    output logic                      m_tlast    // last_of_run
);
    import scp_pkg::*;

    logic             in_valid_reg;
    logic [ByteW-1:0] in_byte_reg;
    logic             fire;
    run_desc_t        desc;
    emit_status_t     emit_sts;

    assign s_tready = !in_valid_reg || fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
    end

    scp_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid_reg),
        .in_byte  (in_byte_reg),
        .emit_sts (emit_sts),
        .fire     (fire),
        .desc     (desc)
    );

    scp_emitter u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire && desc.emit),
        .desc     (desc),
        .sts      (emit_sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Checks
    `SCP_ASSERT_NOW(a_led_not_last, clk, rst_n, m_tvalid && m_tuser, !m_tlast, "led beat is last")
    `SCP_ASSERT_NOW(a_no_run_overwrite, clk, rst_n, fire && desc.emit,
                    !emit_sts.busy || emit_sts.ending, "run loaded over a busy run")
    `SCP_ASSERT_NOW(a_full_accept_drains, clk, rst_n, s_tvalid && s_tready && in_valid_reg,
                    fire, "input register overwritten")
    `SCP_ASSERT_NEXT(a_load_starts_ack, clk, rst_n, fire && desc.emit,
                     m_tvalid && m_tuser && (m_tdata == CH_A), "run does not open with A")

endmodule
